FILE: rtl/core/vps_pkg.sv
package vps_pkg;

  // sequencer phases
  typedef enum logic [2:0] {
    PH_RESET     = 3'd0,
    PH_RESETWAIT = 3'd1,
    PH_IDLE      = 3'd2,
    PH_START     = 3'd3,
    PH_DATA      = 3'd4,
    PH_STOP      = 3'd5
  } phase_t;

  // request kinds
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_MUTE        = 2'd0;
  localparam logic [1:0] CFG_START_TICKS = 2'd1;
  localparam logic [1:0] CFG_STOP_TICKS  = 2'd2;
  localparam logic [1:0] CFG_RESET_TICKS = 2'd3;

  // frame shape and register reset values
  localparam int          CODE_W            = 16;
  localparam logic [4:0]  FRAME_BITS        = 5'd16;
  localparam logic [7:0]  START_TICKS_RESET = 8'd5;
  localparam logic [7:0]  STOP_TICKS_RESET  = 8'd84;
  localparam logic [7:0]  RESET_TICKS_RESET = 8'd4;

  // handshake between sequencer and prompt queue
  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctl_t;

endpackage

FILE: rtl/core/vps_queue.sv
module vps_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  vps_pkg::queue_ctl_t              ctl,
  input  logic [vps_pkg::CODE_W-1:0]       wr_data,
  output logic                             empty,
  output logic [vps_pkg::CODE_W-1:0]       rd_data
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

  logic [vps_pkg::CODE_W-1:0] mem [QUEUE_DEPTH];
  logic [PtrW-1:0] write_ptr;
  logic [PtrW-1:0] read_ptr;

  assign empty = (read_ptr == write_ptr);

  // pointers wrap at the queue depth, no full check
  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr <= '0;
      read_ptr  <= '0;
    end else begin
      if (ctl.push) begin
        write_ptr <= (write_ptr == LastPtr) ? '0 : write_ptr + 1'b1;
      end
      if (ctl.pop) begin
        read_ptr <= (read_ptr == LastPtr) ? '0 : read_ptr + 1'b1;
      end
    end
  end

  // storage with registered read at the head entry
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[write_ptr] <= wr_data;
    end
    rd_data <= mem[read_ptr];
  end

endmodule

FILE: rtl/core/vps_seq.sv
module vps_seq (
  input  logic                           clk,
  input  logic                           rst,
  // accepted item
  input  logic                           item_accept,
  input  logic                           req_type,
  input  logic                           busy_req,
  // configuration write
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [7:0]                     cfg_data,
  // prompt queue
  output vps_pkg::queue_ctl_t            ctl,
  input  logic                           queue_empty,
  input  logic [vps_pkg::CODE_W-1:0]     queue_data,
  // pin levels
  output logic                           clk_pin,
  output logic                           data_pin,
  output logic                           rst_pin,
  output logic                           active
);

  vps_pkg::phase_t phase, phase_next;

  logic       mute;
  logic [7:0] start_ticks;
  logic [7:0] stop_ticks;

  logic [vps_pkg::CODE_W-1:0] shift_word, shift_word_next, shift_cur;
  logic [4:0] bit_count, bit_count_next, bit_count_inc;
  logic [7:0] phase_count, phase_count_next, phase_count_dec;
  logic [7:0] start_dec;
  logic [7:0] reset_count, reset_count_next;
  logic       active_next, clk_pin_next, data_pin_next, rst_pin_next;
  logic       load_pending;
  logic       tick;

  assign tick = item_accept && (req_type == vps_pkg::REQ_TICK) && active;
  assign ctl.push = item_accept && (req_type == vps_pkg::REQ_PUSH) && !mute;
  assign ctl.pop  = tick && (phase == vps_pkg::PH_IDLE) && !queue_empty;

  // freshly popped code arrives from the queue's registered read in the cycle after the pop
  assign shift_cur       = load_pending ? queue_data : shift_word;
  assign phase_count_dec = phase_count - 8'd1;
  assign start_dec       = start_ticks - 8'd1;
  assign bit_count_inc   = bit_count + 5'd1;

  // next phase
  always_comb begin
    phase_next = phase;
    if (tick) begin
      unique case (phase)
        vps_pkg::PH_IDLE: begin
          if (!queue_empty) begin
            phase_next = (start_dec == 8'd0) ? vps_pkg::PH_DATA : vps_pkg::PH_START;
          end
        end
        vps_pkg::PH_START: begin
          if (phase_count_dec == 8'd0) begin
            phase_next = vps_pkg::PH_DATA;
          end
        end
        vps_pkg::PH_DATA: begin
          if (!clk_pin && bit_count_inc == vps_pkg::FRAME_BITS) begin
            phase_next = vps_pkg::PH_STOP;
          end
        end
        vps_pkg::PH_STOP: begin
          if (phase_count_dec == 8'd0 && !busy_req) begin
            phase_next = vps_pkg::PH_IDLE;
          end
        end
        vps_pkg::PH_RESET: begin
          if (reset_count == 8'd0) begin
            phase_next = vps_pkg::PH_RESETWAIT;
          end
        end
        vps_pkg::PH_RESETWAIT: begin
          if (!busy_req) begin
            phase_next = vps_pkg::PH_IDLE;
          end
        end
        default: phase_next = phase;
      endcase
    end
  end

  // pins, counters and shift word
  always_comb begin
    shift_word_next  = shift_cur;
    bit_count_next   = bit_count;
    phase_count_next = phase_count;
    reset_count_next = reset_count;
    active_next      = active;
    clk_pin_next     = clk_pin;
    data_pin_next    = data_pin;
    rst_pin_next     = rst_pin;

    if (ctl.push) begin
      active_next = 1'b1;
    end

    if (tick) begin
      unique case (phase)
        vps_pkg::PH_IDLE: begin
          if (queue_empty) begin
            active_next = 1'b0;
          end else begin
            clk_pin_next     = 1'b0;
            phase_count_next = start_dec;
          end
        end
        vps_pkg::PH_START: begin
          clk_pin_next     = 1'b0;
          phase_count_next = phase_count_dec;
        end
        vps_pkg::PH_DATA: begin
          if (!clk_pin) begin
            // rising clock, data high only for a one bit
            if (shift_cur[vps_pkg::CODE_W-1]) begin
              data_pin_next = 1'b1;
            end
            shift_word_next = {shift_cur[vps_pkg::CODE_W-2:0], 1'b0};
            clk_pin_next    = 1'b1;
            if (bit_count_inc == vps_pkg::FRAME_BITS) begin
              bit_count_next   = 5'd0;
              phase_count_next = stop_ticks;
            end else begin
              bit_count_next = bit_count_inc;
            end
          end else begin
            clk_pin_next  = 1'b0;
            data_pin_next = 1'b0;
          end
        end
        vps_pkg::PH_STOP: begin
          data_pin_next    = 1'b0;
          clk_pin_next     = 1'b1;
          phase_count_next = phase_count_dec;
        end
        vps_pkg::PH_RESET: begin
          if (reset_count != 8'd0) begin
            rst_pin_next     = 1'b0;
            data_pin_next    = 1'b0;
            clk_pin_next     = 1'b1;
            reset_count_next = reset_count - 8'd1;
          end
        end
        vps_pkg::PH_RESETWAIT: begin
          rst_pin_next = 1'b1;
        end
        default: ;
      endcase
    end

    // reset_ticks write reloads the counter while the sequencer is in its reset phase
    if (cfg_write && cfg_index == vps_pkg::CFG_RESET_TICKS && phase == vps_pkg::PH_RESET) begin
      reset_count_next = cfg_data;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= vps_pkg::PH_RESET;
      shift_word   <= '0;
      bit_count    <= '0;
      phase_count  <= vps_pkg::START_TICKS_RESET;
      reset_count  <= vps_pkg::RESET_TICKS_RESET;
      active       <= 1'b1;
      clk_pin      <= 1'b0;
      data_pin     <= 1'b0;
      rst_pin      <= 1'b0;
      load_pending <= 1'b0;
    end else begin
      phase        <= phase_next;
      shift_word   <= shift_word_next;
      bit_count    <= bit_count_next;
      phase_count  <= phase_count_next;
      reset_count  <= reset_count_next;
      active       <= active_next;
      clk_pin      <= clk_pin_next;
      data_pin     <= data_pin_next;
      rst_pin      <= rst_pin_next;
      load_pending <= ctl.pop;
    end
  end

  // configuration registers; reset_ticks only acts through the counter reload
  always_ff @(posedge clk) begin
    if (rst) begin
      mute        <= 1'b0;
      start_ticks <= vps_pkg::START_TICKS_RESET;
      stop_ticks  <= vps_pkg::STOP_TICKS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        vps_pkg::CFG_MUTE:        mute        <= cfg_data[0];
        vps_pkg::CFG_START_TICKS: start_ticks <= cfg_data;
        vps_pkg::CFG_STOP_TICKS:  stop_ticks  <= cfg_data;
        vps_pkg::CFG_RESET_TICKS: ;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/voice_prompt_serial_sender.sv
// Voice prompt serial sender. Each accepted item is either a prompt push or one
// timer tick; every item yields exactly one result carrying the clock, data and
// reset pin levels and the playing flag after that item. The pin state and the
// prompt queue update at the accepting edge and the result register shows the
// new levels in the next cycle, so one item per clock is sustained while the
// result side keeps taking. The result register is the only stage between the
// two sides; a stalled result holds new input back. Queued codes are read from
// a registered-output memory of QUEUE_DEPTH entries; pushes beyond its depth
// overwrite queued codes. No clearing pass after reset.
module voice_prompt_serial_sender #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [15:0] prompt,
  input  logic        busy_req,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        clk_level,
  output logic        data_level,
  output logic        reset_level,
  output logic        playing,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  vps_pkg::queue_ctl_t ctl;
  logic                queue_empty;
  logic [15:0]         queue_data;
  logic                item_accept;

  assign in_ready    = !out_valid || out_ready;
  assign item_accept = in_valid && in_ready;
  assign cfg_ready   = 1'b1;

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  vps_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .wr_data (prompt),
    .empty   (queue_empty),
    .rd_data (queue_data)
  );

  vps_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .item_accept (item_accept),
    .req_type    (req_type),
    .busy_req    (busy_req),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .ctl         (ctl),
    .queue_empty (queue_empty),
    .queue_data  (queue_data),
    .clk_pin     (clk_level),
    .data_pin    (data_level),
    .rst_pin     (reset_level),
    .active      (playing)
  );

endmodule
